[hw/rtl/dpim_pkg.sv]
// dpim_pkg: shared constants and types for the dithered palette index mapper.
// No dependencies; imported by dithered_palette_index_mapper.
`default_nettype none
package dpim_pkg;

  localparam int MaxWidthDef      = 2048;
  localparam int PaletteDepthDef  = 256;
  localparam int ErrorFracBitsDef = 4;
  localparam int MaxHeight        = 4096;
  localparam int RowTagW          = 12;   // row numbers 0..MaxHeight-1
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 13;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DITHER_EN   = 3'd0,
    CFG_TRANSP_EN   = 3'd1,
    CFG_TRANSP_SLOT = 3'd2,
    CFG_ALPHA_LIM   = 3'd3,
    CFG_PAL_SIZE    = 3'd4,
    CFG_IMG_W       = 3'd5,
    CFG_IMG_H       = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CUR_RD,
    ST_CUR_CALC,
    ST_SEARCH,
    ST_FETCH,
    ST_ERR,
    ST_SPRD_RD,
    ST_SPRD_WR,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

[hw/rtl/dithered_palette_index_mapper.sv]
// dithered_palette_index_mapper: nearest-palette search with optional
// Floyd-Steinberg error diffusion. Depends on dpim_pkg.
//
// Usage: configuration is written through cfg_we/cfg_index/cfg_wdata while
// the block is idle. Input transactions (in_valid/in_stall) carry either a
// palette load (opcode 0, no result) or a pixel to map (opcode 1, exactly
// one out_color_index transaction on out_valid/out_stall).
// A load does not raise in_stall. A pixel searching N palette entries keeps
// in_stall high while it is processed: one palette memory read per cycle
// through a shared distance unit, a pipeline tail and a result step (the scan
// ends early on an exact match). A new pixel is accepted only once the
// previous one has been registered as a result. Dithering adds the error read
// and four error read-modify-writes. A transparent pixel skips the search and
// the dithering. The first pixel of a frame, when error rows hold data (and
// after reset), first runs a clearing pass over all 2*(MAX_WIDTH+2) words of
// the error memory. A finished result waits in the output register while
// out_stall is high; a following pixel holds in its result step until it is
// taken. Reset (rst_n, synchronous) returns configuration to its defaults, the
// raster position to the frame start and clears out_valid; palette contents
// are undefined until loaded.
`default_nettype none
module dithered_palette_index_mapper #(
  parameter int MAX_WIDTH       = dpim_pkg::MaxWidthDef,
  parameter int PALETTE_DEPTH   = dpim_pkg::PaletteDepthDef,
  parameter int ERROR_FRAC_BITS = dpim_pkg::ErrorFracBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dpim_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [dpim_pkg::CfgDataW-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_opcode,
  input  wire logic [7:0]                    in_entry_slot,
  input  wire logic [7:0]                    in_red,
  input  wire logic [7:0]                    in_green,
  input  wire logic [7:0]                    in_blue,
  input  wire logic [7:0]                    in_alpha,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [7:0]                         out_color_index
);
  import dpim_pkg::*;

  localparam int F        = ERROR_FRAC_BITS;
  localparam int VW       = F + 8;              // clamped channel value
  localparam int EW       = F + 10;             // signed error per channel
  localparam int EMW      = 1 + RowTagW + 3 * EW;
  localparam int RowSlots = MAX_WIDTH + 2;
  localparam int SLOT_W   = $clog2(RowSlots);
  localparam int EM_DEPTH = 2 * RowSlots;
  localparam int EM_AW    = $clog2(EM_DEPTH);
  localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PAL_AW   = $clog2(PALETTE_DEPTH);
  localparam logic [VW:0] TopVal = VW'(255) << F;

  // configuration
  logic        dither_en_r, transp_en_r;
  logic [7:0]  transp_slot_r, alpha_lim_r;
  logic [8:0]  pal_size_r;
  logic [11:0] img_w_r;
  logic [12:0] img_h_r;

  state_t state_r, state_nxt;

  logic [7:0]        pix_r [3];
  logic [7:0]        ch_r [3];
  logic [VW-1:0]     val_r [3];
  logic signed [EW-1:0] err_r [3];
  logic              dith_r, transp_r;
  logic [COL_W-1:0]  col_r;
  logic [RowTagW-1:0] row_r;
  logic              dirty_r;
  logic [EM_AW-1:0]  clr_cnt_r;
  logic [8:0]        rd_i_r;
  logic              cmp_v_r, stop_r;
  logic [PAL_AW-1:0] cmp_idx_r, best_idx_r;
  logic [17:0]       best_d_r;
  logic [1:0]        tgt_r;
  logic              out_valid_r;
  logic [7:0]        out_index_r;

  // memories
  logic [23:0]    pal_mem [PALETTE_DEPTH];
  logic [23:0]    pal_q;
  logic [PAL_AW-1:0] pal_raddr;
  logic           pal_we;
  logic [EMW-1:0] em_mem [EM_DEPTH];
  logic [EMW-1:0] em_q, em_wdata;
  logic [EM_AW-1:0] em_raddr, em_waddr;
  logic           em_we;

  // derived
  logic        accept;
  logic        frame_start;
  logic [8:0]  n_eff;
  logic [13:0] w_eff, x_p1;
  logic [12:0] h_eff, y_p1;
  logic        has_right, has_below;
  logic [RowTagW-1:0] tag_cur, tag_nxt;
  logic [17:0] sq_dist;
  logic        search_done;
  logic        result_go;
  logic signed [EW-1:0] base [3];
  logic [VW-1:0] val_c [3];
  logic [7:0]    ch_c [3];
  logic signed [EW-1:0] err_c [3];
  logic [EW-1:0] upd [3];
  logic [SLOT_W-1:0] tgt_slot;
  logic        tgt_bank, tgt_en;
  logic [RowTagW-1:0] tgt_tag;
  logic [3:0]  tgt_k;

  function automatic logic [EM_AW-1:0] em_addr(input logic bank, input logic [SLOT_W-1:0] s);
    logic [EM_AW-1:0] a;
    a = EM_AW'(s);
    if (bank) a = a + EM_AW'(RowSlots);
    return a;
  endfunction

  assign accept      = in_valid && !in_stall;
  assign frame_start = (col_r == '0) && (row_r == '0);
  assign n_eff = (pal_size_r > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : pal_size_r;

  always_comb begin
    w_eff = (img_w_r == '0) ? 14'd1 : {2'b0, img_w_r};
    if (w_eff > 14'(MAX_WIDTH)) w_eff = 14'(MAX_WIDTH);
    h_eff = (img_h_r == '0) ? 13'd1 : img_h_r;
    if (h_eff > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
  end

  assign x_p1      = 14'(col_r) + 14'd1;
  assign y_p1      = 13'(row_r) + 13'd1;
  assign has_right = x_p1 < w_eff;
  assign has_below = y_p1 < h_eff;
  assign tag_cur   = row_r;
  assign tag_nxt   = RowTagW'(y_p1);

  // shared distance unit
  always_comb begin
    logic signed [9:0]  dr, dg, db;
    logic signed [19:0] sr, sg, sb;
    dr = $signed({2'b0, ch_r[0]}) - $signed({2'b0, pal_q[23:16]});
    dg = $signed({2'b0, ch_r[1]}) - $signed({2'b0, pal_q[15:8]});
    db = $signed({2'b0, ch_r[2]}) - $signed({2'b0, pal_q[7:0]});
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    sq_dist = 18'(sr[16:0]) + 18'(sg[16:0]) + 18'(sb[16:0]);
  end

  assign search_done = stop_r || ((rd_i_r >= n_eff) && !cmp_v_r);
  assign result_go   = !out_valid_r || !out_stall;

  // error word fields, stale entries read as zero
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic tag_ok;
      tag_ok = em_q[EMW-1] &&
               (em_q[EMW-2 -: RowTagW] == ((state_r == ST_CUR_CALC) ? tag_cur : tgt_tag));
      base[c] = tag_ok ? $signed(em_q[(3-c)*EW-1 -: EW]) : '0;
    end
  end

  // carried error plus pixel, clamp and round
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [EW:0] s;
      logic [VW:0] r;
      s = $signed({{(EW+1-VW){1'b0}}, pix_r[c], {F{1'b0}}}) + $signed({base[c][EW-1], base[c]});
      if (s < 0) val_c[c] = '0;
      else if (s > $signed({{(EW-VW){1'b0}}, TopVal})) val_c[c] = TopVal[VW-1:0];
      else val_c[c] = s[VW-1:0];
      r = {1'b0, val_c[c]} + (VW+1)'(1 << (F-1));
      ch_c[c] = r[F+7:F];
    end
  end

  always_comb begin
    logic [VW-1:0] p [3];
    p[0] = {pal_q[23:16], {F{1'b0}}};
    p[1] = {pal_q[15:8],  {F{1'b0}}};
    p[2] = {pal_q[7:0],   {F{1'b0}}};
    for (int c = 0; c < 3; c++)
      err_c[c] = $signed({{(EW-VW){1'b0}}, val_r[c]}) - $signed({{(EW-VW){1'b0}}, p[c]});
  end

  // spread targets: right, lower-left, below, lower-right
  always_comb begin
    unique case (tgt_r)
      2'd0: begin
        tgt_slot = SLOT_W'(col_r) + SLOT_W'(2); tgt_bank = row_r[0];
        tgt_tag = tag_cur; tgt_k = 4'd7; tgt_en = has_right;
      end
      2'd1: begin
        tgt_slot = SLOT_W'(col_r); tgt_bank = !row_r[0];
        tgt_tag = tag_nxt; tgt_k = 4'd3; tgt_en = has_below && (col_r != '0);
      end
      2'd2: begin
        tgt_slot = SLOT_W'(col_r) + SLOT_W'(1); tgt_bank = !row_r[0];
        tgt_tag = tag_nxt; tgt_k = 4'd5; tgt_en = has_below;
      end
      default: begin
        tgt_slot = SLOT_W'(col_r) + SLOT_W'(2); tgt_bank = !row_r[0];
        tgt_tag = tag_nxt; tgt_k = 4'd1; tgt_en = has_below && has_right;
      end
    endcase
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic signed [EW+4:0] prod;
      logic signed [EW+4:0] sh;
      prod = $signed({err_r[c][EW-1], err_r[c][EW-1], err_r[c][EW-1], err_r[c][EW-1],
                      err_r[c][EW-1], err_r[c]}) * $signed({1'b0, tgt_k});
      sh = prod >>> 4;                              // floor of k/16 share
      upd[c] = base[c] + sh[EW-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_opcode == OP_MAP) begin
          if (frame_start && dirty_r) state_nxt = ST_CLEAR;
          else if (transp_en_r && in_alpha < alpha_lim_r) state_nxt = ST_RESULT;
          else if (dither_en_r) state_nxt = ST_CUR_RD;
          else state_nxt = ST_SEARCH;
        end
      end
      ST_CLEAR: begin
        if (clr_cnt_r == EM_AW'(EM_DEPTH - 1)) begin
          if (transp_r) state_nxt = ST_RESULT;
          else if (dith_r) state_nxt = ST_CUR_RD;
          else state_nxt = ST_SEARCH;
        end
      end
      ST_CUR_RD:   state_nxt = ST_CUR_CALC;
      ST_CUR_CALC: state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (search_done) state_nxt = dith_r ? ST_FETCH : ST_RESULT;
      end
      ST_FETCH:   state_nxt = ST_ERR;
      ST_ERR:     state_nxt = ST_SPRD_RD;
      ST_SPRD_RD: state_nxt = ST_SPRD_WR;
      ST_SPRD_WR: state_nxt = (tgt_r == 2'd3) ? ST_RESULT : ST_SPRD_RD;
      ST_RESULT:  if (result_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    pal_we    = accept && (in_opcode == OP_LOAD) && ({1'b0, in_entry_slot} < 9'(PALETTE_DEPTH));
    pal_raddr = (state_r == ST_SEARCH) ? rd_i_r[PAL_AW-1:0] : best_idx_r;
    em_we     = 1'b0;
    em_waddr  = em_addr(tgt_bank, tgt_slot);
    em_wdata  = {1'b1, tgt_tag, upd[0], upd[1], upd[2]};
    em_raddr  = em_addr(tgt_bank, tgt_slot);
    unique case (state_r)
      ST_CLEAR: begin
        em_we    = 1'b1;
        em_waddr = clr_cnt_r;
        em_wdata = '0;
      end
      ST_CUR_RD:  em_raddr = em_addr(row_r[0], SLOT_W'(col_r) + SLOT_W'(1));
      ST_SPRD_WR: em_we = tgt_en;
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_index_r;

  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[in_entry_slot[PAL_AW-1:0]] <= {in_red, in_green, in_blue};
    pal_q <= pal_mem[pal_raddr];
  end

  always_ff @(posedge clk) begin
    if (em_we) em_mem[em_waddr] <= em_wdata;
    em_q <= em_mem[em_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      dither_en_r   <= 1'b0;
      transp_en_r   <= 1'b0;
      transp_slot_r <= '0;
      alpha_lim_r   <= '0;
      pal_size_r    <= 9'd256;
      img_w_r       <= 12'd1;
      img_h_r       <= 13'd1;
      col_r         <= '0;
      row_r         <= '0;
      dirty_r       <= 1'b1;   // error memory content unknown after reset
      clr_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
      cmp_v_r       <= 1'b0;
      stop_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DITHER_EN:   dither_en_r   <= cfg_wdata[0];
          CFG_TRANSP_EN:   transp_en_r   <= cfg_wdata[0];
          CFG_TRANSP_SLOT: transp_slot_r <= cfg_wdata[7:0];
          CFG_ALPHA_LIM:   alpha_lim_r   <= cfg_wdata[7:0];
          CFG_PAL_SIZE:    pal_size_r    <= cfg_wdata[8:0];
          CFG_IMG_W:       img_w_r       <= cfg_wdata[11:0];
          CFG_IMG_H:       img_h_r       <= cfg_wdata[12:0];
          default: ;
        endcase
      end

      if (state_r == ST_RESULT && result_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_opcode == OP_MAP) begin
            pix_r[0] <= in_red;
            pix_r[1] <= in_green;
            pix_r[2] <= in_blue;
            ch_r[0]  <= in_red;
            ch_r[1]  <= in_green;
            ch_r[2]  <= in_blue;
            transp_r <= transp_en_r && (in_alpha < alpha_lim_r);
            dith_r   <= dither_en_r;
            clr_cnt_r <= '0;
          end
        end
        ST_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + EM_AW'(1);
          if (clr_cnt_r == EM_AW'(EM_DEPTH - 1)) dirty_r <= 1'b0;
        end
        ST_CUR_CALC: begin
          for (int c = 0; c < 3; c++) begin
            val_r[c] <= val_c[c];
            ch_r[c]  <= ch_c[c];
          end
        end
        ST_SEARCH: begin
          cmp_v_r   <= (rd_i_r < n_eff);
          cmp_idx_r <= rd_i_r[PAL_AW-1:0];
          if (rd_i_r < n_eff) rd_i_r <= rd_i_r + 9'd1;
          if (cmp_v_r && !stop_r && sq_dist < best_d_r) begin
            best_d_r   <= sq_dist;
            best_idx_r <= cmp_idx_r;
            if (sq_dist == '0) stop_r <= 1'b1;   // exact match ends the scan
          end
        end
        ST_ERR: begin
          for (int c = 0; c < 3; c++) err_r[c] <= err_c[c];
          tgt_r <= 2'd0;
        end
        ST_SPRD_WR: begin
          tgt_r <= tgt_r + 2'd1;
          if (tgt_en) dirty_r <= 1'b1;
        end
        ST_RESULT: begin
          if (result_go) begin
            out_index_r <= transp_r ? transp_slot_r : 8'(best_idx_r);
            if (!has_right) begin
              col_r <= '0;
              row_r <= has_below ? RowTagW'(y_p1) : '0;
            end else begin
              col_r <= COL_W'(x_p1);
            end
          end
        end
        default: ;
      endcase

      // search setup on entry
      if (state_nxt == ST_SEARCH && state_r != ST_SEARCH) begin
        rd_i_r     <= '0;
        cmp_v_r    <= 1'b0;
        stop_r     <= 1'b0;
        best_idx_r <= '0;
        best_d_r   <= '1;
      end
      if (state_nxt == ST_RESULT && state_r != ST_SEARCH && state_r != ST_SPRD_WR
          && state_r != ST_RESULT)
        best_idx_r <= '0;
    end
  end

endmodule
`default_nettype wire
